>>> rtl/rrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_pkg: shared types and constants of the register rename scoreboard
// Field widths, operation and status codes, the request and result layouts,
// and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int OP_W      = 3;
	localparam int ARCH_FW   = 6;
	localparam int PHYS_FW   = 7;
	localparam int LAT_W     = 8;
	localparam int STATUS_W  = 2;
	localparam int SB_W      = 9;
	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 56;

	// Operation codes carried on the input side band.
	localparam logic [OP_W-1:0] OP_RENAME = 3'd0;
	localparam logic [OP_W-1:0] OP_COMMIT = 3'd1;
	localparam logic [OP_W-1:0] OP_ISSUE  = 3'd2;
	localparam logic [OP_W-1:0] OP_TICK   = 3'd3;
	localparam logic [OP_W-1:0] OP_QUERY  = 3'd4;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STS_SHORT    = 2'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW = 2'd2;

	// A register field that carries no register.
	localparam logic [PHYS_FW-1:0] PHYS_NONE = 7'h7F;

	// Scoreboard value of a register whose producer has not issued yet.
	localparam logic [SB_W-1:0] SB_PENDING = 9'h1FF;

	// Request payload, last field in the lowest bits.
	typedef struct packed {
		logic        [LAT_W-1:0]   latency;
		logic signed [PHYS_FW-1:0] phys_3;
		logic signed [PHYS_FW-1:0] phys_2;
		logic signed [PHYS_FW-1:0] phys_1;
		logic signed [ARCH_FW-1:0] dst_arch_2;
		logic signed [ARCH_FW-1:0] dst_arch_1;
		logic signed [ARCH_FW-1:0] src_arch_3;
		logic signed [ARCH_FW-1:0] src_arch_2;
		logic signed [ARCH_FW-1:0] src_arch_1;
	} rrs_data_t;

	// Result payload, last field in the lowest bits.
	typedef struct packed {
		logic                      ready_res;
		logic signed [PHYS_FW-1:0] old_phys_2;
		logic signed [PHYS_FW-1:0] old_phys_1;
		logic signed [PHYS_FW-1:0] dst_phys_2;
		logic signed [PHYS_FW-1:0] dst_phys_1;
		logic signed [PHYS_FW-1:0] src_phys_3;
		logic signed [PHYS_FW-1:0] src_phys_2;
		logic signed [PHYS_FW-1:0] src_phys_1;
		logic        [STATUS_W-1:0] status;
	} rrs_res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       map_rd_src;
		logic       map_rd_dst;
		logic       fifo_rd;
		logic       cap_src;
		logic       alloc;
		logic       push;
		logic       issue;
		logic       sb_rd;
		logic       sb_chk;
		logic       tick_clr;
		logic       tick_step;
		logic       set_short;
		logic       set_ovf;
		logic       out_load;
		logic [1:0] rd_sel;
		logic [1:0] cap_sel;
	} rrs_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            short_regs;
		logic            overflow;
		logic            tick_last;
	} rrs_sts_t;

endpackage
`default_nettype wire

>>> rtl/rrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_ctrl: sequencer of the register rename scoreboard
// Accepts one request at a time, steps the datapath through the memory
// accesses of its operation and hands the result to the output register.
// ----------------------------------------------------------------------------
module rrs_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	input  rrs_pkg::rrs_sts_t  sts,
	output rrs_pkg::rrs_cmd_t  cmd
);
	import rrs_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE   = 10'b00_0000_0001,
		S_DECODE = 10'b00_0000_0010,
		S_RN_SRC = 10'b00_0000_0100,
		S_RN_DRD = 10'b00_0000_1000,
		S_RN_DWR = 10'b00_0001_0000,
		S_COMMIT = 10'b00_0010_0000,
		S_ISSUE  = 10'b00_0100_0000,
		S_TICK   = 10'b00_1000_0000,
		S_QUERY  = 10'b01_0000_0000,
		S_DONE   = 10'b10_0000_0000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] cnt_q, cnt_d;
	logic       out_valid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cnt_d = 2'd0;
				unique case (sts.op)
					OP_RENAME: begin
						if (sts.short_regs) begin
							cmd.set_short = 1'b1;
							state_d       = S_DONE;
						end else begin
							state_d = S_RN_SRC;
						end
					end
					OP_COMMIT: begin
						if (sts.overflow) begin
							cmd.set_ovf = 1'b1;
							state_d     = S_DONE;
						end else begin
							state_d = S_COMMIT;
						end
					end
					OP_ISSUE: state_d = S_ISSUE;
					OP_TICK: begin
						cmd.tick_clr = 1'b1;
						state_d      = S_TICK;
					end
					OP_QUERY: state_d = S_QUERY;
					default: state_d = S_DONE;
				endcase
			end
			S_RN_SRC: begin
				// Read one source mapping per cycle, capture it the cycle after.
				cmd.map_rd_src = (cnt_q != 2'd3);
				cmd.rd_sel     = cnt_q;
				cmd.cap_src    = (cnt_q != 2'd0);
				cmd.cap_sel    = cnt_q - 2'd1;
				if (cnt_q == 2'd3) begin
					cnt_d   = 2'd0;
					state_d = S_RN_DRD;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			S_RN_DRD: begin
				cmd.map_rd_dst = 1'b1;
				cmd.fifo_rd    = 1'b1;
				cmd.rd_sel     = cnt_q;
				state_d        = S_RN_DWR;
			end
			S_RN_DWR: begin
				cmd.alloc   = 1'b1;
				cmd.cap_sel = cnt_q;
				if (cnt_q == 2'd1) begin
					cnt_d   = 2'd0;
					state_d = S_DONE;
				end else begin
					cnt_d   = 2'd1;
					state_d = S_RN_DRD;
				end
			end
			S_COMMIT: begin
				cmd.push   = 1'b1;
				cmd.rd_sel = cnt_q;
				if (cnt_q == 2'd1) begin
					cnt_d   = 2'd0;
					state_d = S_DONE;
				end else begin
					cnt_d = 2'd1;
				end
			end
			S_ISSUE: begin
				cmd.issue  = 1'b1;
				cmd.rd_sel = cnt_q;
				if (cnt_q == 2'd1) begin
					cnt_d   = 2'd0;
					state_d = S_DONE;
				end else begin
					cnt_d = 2'd1;
				end
			end
			S_TICK: begin
				cmd.tick_step = 1'b1;
				if (sts.tick_last) begin
					state_d = S_DONE;
				end
			end
			S_QUERY: begin
				cmd.sb_rd   = (cnt_q != 2'd3);
				cmd.rd_sel  = cnt_q;
				cmd.sb_chk  = (cnt_q != 2'd0);
				cmd.cap_sel = cnt_q - 2'd1;
				if (cnt_q == 2'd3) begin
					cnt_d   = 2'd0;
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 2'd1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/rrs_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrs_datapath: map table, free list and scoreboard storage
// Holds the three memories with registered read ports, the free list
// pointers, the request registers and the result and output registers.
// ----------------------------------------------------------------------------
module rrs_datapath #(
	parameter int ARCH_REGS = 32,
	parameter int PHYS_REGS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  rrs_pkg::rrs_cmd_t                  cmd,
	output rrs_pkg::rrs_sts_t                  sts,
	input  wire [rrs_pkg::OP_W-1:0]            in_op,
	input  rrs_pkg::rrs_data_t                 in_data,
	output rrs_pkg::rrs_res_t                  out_res
);
	import rrs_pkg::*;

	localparam int AW    = (ARCH_REGS > 1) ? $clog2(ARCH_REGS) : 1;
	localparam int PW    = $clog2(PHYS_REGS);
	localparam int CAP   = (PHYS_REGS > ARCH_REGS) ? PHYS_REGS - ARCH_REGS : 0;
	localparam int DEPTH = (CAP > 0) ? CAP : 1;
	localparam int HW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = (CAP > 0) ? $clog2(CAP + 1) : 1;
	localparam int TW    = $clog2(PHYS_REGS + 1);

	// Request registers.
	logic [OP_W-1:0] op_q;
	rrs_data_t       item_q;

	// Free list control.
	logic [HW-1:0] head_q, tail_q;
	logic          tail_wrap_q;
	logic [CW-1:0] count_q;

	// Memories and their read registers.
	logic [PW-1:0]        map_mem [ARCH_REGS];
	logic [ARCH_REGS-1:0] map_vld_q;
	logic [PW-1:0]        map_rdata_q;
	logic [AW-1:0]        map_raddr_q;
	logic                 map_init_q;

	logic [PW-1:0] fifo_mem [DEPTH];
	logic [PW-1:0] fifo_rdata_q;
	logic [HW-1:0] fifo_rptr_q;
	logic          fifo_init_q;

	logic [SB_W-1:0]      sb_mem [PHYS_REGS];
	logic [PHYS_REGS-1:0] sb_vld_q;
	logic [SB_W-1:0]      sb_rdata_q;
	logic                 sb_init_q;
	logic [TW-1:0]        tick_ctr_q;

	// Result under construction.
	logic [STATUS_W-1:0] res_status_q;
	logic [PHYS_FW-1:0]  res_src_q [3];
	logic [PHYS_FW-1:0]  res_dst_q [2];
	logic [PHYS_FW-1:0]  res_old_q [2];
	logic                res_ready_q;
	rrs_res_t            out_q;

	// Decoded request fields.
	logic [ARCH_FW-1:0] src_a [3];
	logic [ARCH_FW-1:0] dst_a [2];
	logic [PHYS_FW-1:0] ph    [3];
	logic [2:0]         src_vld;
	logic [AW-1:0]      src_idx [3];
	logic [1:0]         dst_vld;
	logic [AW-1:0]      dst_idx [2];
	logic [2:0]         ph_vld;
	logic [PW-1:0]      ph_idx [3];
	logic [1:0]         need, n_push;

	logic [AW-1:0]   map_raddr;
	logic [PW-1:0]   map_val, fifo_val;
	logic [SB_W-1:0] sb_val, sb_dec;
	logic            alloc_en, push_en, issue_en;
	logic            tick_rd, tick_wr;
	logic            sb_re, sb_we;
	logic [PW-1:0]   sb_raddr, sb_waddr;
	logic [SB_W-1:0] sb_wdata;

	function automatic logic [HW-1:0] next_pos(input logic [HW-1:0] p);
		return (p == HW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		src_a[0] = item_q.src_arch_1;
		src_a[1] = item_q.src_arch_2;
		src_a[2] = item_q.src_arch_3;
		dst_a[0] = item_q.dst_arch_1;
		dst_a[1] = item_q.dst_arch_2;
		ph[0]    = item_q.phys_1;
		ph[1]    = item_q.phys_2;
		ph[2]    = item_q.phys_3;
		for (int i = 0; i < 3; i++) begin
			src_vld[i] = !src_a[i][ARCH_FW-1] && (7'(src_a[i][4:0]) < 7'(ARCH_REGS));
			src_idx[i] = AW'(src_a[i][4:0]);
			ph_vld[i]  = !ph[i][PHYS_FW-1] && (9'(ph[i][5:0]) < 9'(PHYS_REGS));
			ph_idx[i]  = PW'(ph[i][5:0]);
		end
		for (int j = 0; j < 2; j++) begin
			dst_vld[j] = !dst_a[j][ARCH_FW-1] && (7'(dst_a[j][4:0]) < 7'(ARCH_REGS));
			dst_idx[j] = AW'(dst_a[j][4:0]);
		end
		need   = {1'b0, dst_vld[0]} + {1'b0, dst_vld[1]};
		n_push = {1'b0, ph_vld[0]} + {1'b0, ph_vld[1]};
	end

	assign sts.op         = op_q;
	assign sts.short_regs = (CW+2)'(count_q) < (CW+2)'(need);
	assign sts.overflow   = ((CW+2)'(count_q) + (CW+2)'(n_push)) > (CW+2)'(CAP);
	assign sts.tick_last  = (tick_ctr_q == TW'(PHYS_REGS));

	// Entries never written since reset read as their reset contents.
	assign map_val  = map_init_q ? PW'(map_raddr_q) : map_rdata_q;
	assign fifo_val = fifo_init_q ? PW'(ARCH_REGS) + PW'(fifo_rptr_q) : fifo_rdata_q;
	assign sb_val   = sb_init_q ? '0 : sb_rdata_q;
	assign sb_dec   = (!sb_val[SB_W-1] && sb_val != '0) ? sb_val - 1'b1 : sb_val;

	assign map_raddr = cmd.map_rd_dst ? dst_idx[cmd.rd_sel[0]] : src_idx[cmd.rd_sel];
	assign alloc_en  = cmd.alloc && dst_vld[cmd.cap_sel[0]];
	assign push_en   = cmd.push && ph_vld[cmd.rd_sel];
	assign issue_en  = cmd.issue && ph_vld[cmd.rd_sel];
	assign tick_rd   = cmd.tick_step && (tick_ctr_q < TW'(PHYS_REGS));
	assign tick_wr   = cmd.tick_step && (tick_ctr_q != '0);

	assign sb_re    = cmd.sb_rd || tick_rd;
	assign sb_raddr = tick_rd ? PW'(tick_ctr_q) : ph_idx[cmd.rd_sel];
	assign sb_we    = alloc_en || issue_en || tick_wr;

	always_comb begin
		if (alloc_en) begin
			sb_waddr = fifo_val;
			sb_wdata = SB_PENDING;
		end else if (issue_en) begin
			sb_waddr = ph_idx[cmd.rd_sel];
			sb_wdata = {1'b0, item_q.latency};
		end else begin
			sb_waddr = PW'(tick_ctr_q - 1'b1);
			sb_wdata = sb_dec;
		end
	end

	// Memory arrays and read ports.
	always_ff @(posedge clk) begin
		if (cmd.map_rd_src || cmd.map_rd_dst) begin
			map_rdata_q <= map_mem[map_raddr];
			map_raddr_q <= map_raddr;
			map_init_q  <= !map_vld_q[map_raddr];
		end
		if (alloc_en) begin
			map_mem[dst_idx[cmd.cap_sel[0]]] <= fifo_val;
		end
		if (cmd.fifo_rd) begin
			fifo_rdata_q <= fifo_mem[head_q];
			fifo_rptr_q  <= head_q;
			fifo_init_q  <= !(tail_wrap_q || head_q < tail_q);
		end
		if (push_en) begin
			fifo_mem[tail_q] <= ph_idx[cmd.rd_sel];
		end
		if (sb_re) begin
			sb_rdata_q <= sb_mem[sb_raddr];
			sb_init_q  <= !sb_vld_q[sb_raddr];
		end
		if (sb_we) begin
			sb_mem[sb_waddr] <= sb_wdata;
		end
	end

	// Free list pointers, written marks and the sweep counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			tail_wrap_q <= 1'b0;
			count_q     <= CW'(CAP);
			map_vld_q   <= '0;
			sb_vld_q    <= '0;
			tick_ctr_q  <= '0;
		end else begin
			if (alloc_en) begin
				head_q                            <= next_pos(head_q);
				count_q                           <= count_q - 1'b1;
				map_vld_q[dst_idx[cmd.cap_sel[0]]] <= 1'b1;
			end else if (push_en) begin
				tail_q  <= next_pos(tail_q);
				count_q <= count_q + 1'b1;
				if (tail_q == HW'(DEPTH - 1)) begin
					tail_wrap_q <= 1'b1;
				end
			end
			if (sb_we) begin
				sb_vld_q[sb_waddr] <= 1'b1;
			end
			if (cmd.tick_clr) begin
				tick_ctr_q <= '0;
			end else if (tick_rd) begin
				tick_ctr_q <= tick_ctr_q + 1'b1;
			end
		end
	end

	// Request and result registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q         <= in_op;
			item_q       <= in_data;
			res_status_q <= STS_OK;
			res_ready_q  <= (in_op == OP_QUERY);
			for (int i = 0; i < 3; i++) begin
				res_src_q[i] <= PHYS_NONE;
			end
			for (int j = 0; j < 2; j++) begin
				res_dst_q[j] <= PHYS_NONE;
				res_old_q[j] <= PHYS_NONE;
			end
		end
		if (cmd.set_short) begin
			res_status_q <= STS_SHORT;
		end
		if (cmd.set_ovf) begin
			res_status_q <= STS_OVERFLOW;
		end
		if (cmd.cap_src && src_vld[cmd.cap_sel]) begin
			res_src_q[cmd.cap_sel] <= PHYS_FW'(map_val);
		end
		if (alloc_en) begin
			res_dst_q[cmd.cap_sel[0]] <= PHYS_FW'(fifo_val);
			res_old_q[cmd.cap_sel[0]] <= PHYS_FW'(map_val);
		end
		if (cmd.sb_chk && ph_vld[cmd.cap_sel] && sb_val != '0) begin
			res_ready_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_q.status     <= res_status_q;
			out_q.src_phys_1 <= res_src_q[0];
			out_q.src_phys_2 <= res_src_q[1];
			out_q.src_phys_3 <= res_src_q[2];
			out_q.dst_phys_1 <= res_dst_q[0];
			out_q.dst_phys_2 <= res_dst_q[1];
			out_q.old_phys_1 <= res_old_q[0];
			out_q.old_phys_2 <= res_old_q[1];
			out_q.ready_res  <= res_ready_q;
		end
	end

	assign out_res = out_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CW+1)'(count_q) <= (CW+1)'(CAP))
		else $error("free register count above free list capacity");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		alloc_en |-> count_q != '0)
		else $error("allocation from an empty free list");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push_en |-> (CW+1)'(count_q) < (CW+1)'(CAP))
		else $error("push onto a full free list");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CW'(CAP)) |-> head_q == tail_q)
		else $error("free list pointers disagree with the count");
`endif

endmodule
`default_nettype wire

>>> rtl/register_rename_scoreboard.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// register_rename_scoreboard: rename map, free list and scoreboard
// Top level: stream ports, request unpacking and result packing around the
// controller and the datapath.
// ----------------------------------------------------------------------------
// The block takes one request at a time on the input stream and returns
// exactly one result for it on the output stream. The operation code travels
// on s_axis_tuser: rename (0), commit free (1), issue mark (2), tick (3) and
// ready query (4); other codes return an all-default result. The map table,
// the free list and the scoreboard are memories with one write port and one
// registered read port, so each request is worked through one memory read
// per cycle. A rename refused for lack of free registers and a commit that
// would overflow go straight from decoding to the result, and a tick sweeps
// every scoreboard entry with a read of one entry and a write-back of the
// previous one per cycle. The next request is taken at the edge after the
// result is loaded, even while that result still waits for the consumer.
// Reset contents of all three memories come from per-entry written marks
// and the free list tail position, so no clearing pass follows reset.
module register_rename_scoreboard #(
	parameter int ARCH_REGS = 32,
	parameter int PHYS_REGS = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// Fields from bit 0 up: src_arch_1, src_arch_2, src_arch_3, dst_arch_1,
	// dst_arch_2, phys_1, phys_2, phys_3, latency, then zero fill.
	input  wire [rrs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// Fields from bit 0 up: op.
	input  wire [rrs_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// Fields from bit 0 up: status, src_phys_1, src_phys_2, src_phys_3,
	// dst_phys_1, dst_phys_2, old_phys_1, old_phys_2, ready_res, then zero fill.
	output logic [rrs_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
	import rrs_pkg::*;

	rrs_cmd_t  cmd;
	rrs_sts_t  sts;
	rrs_data_t in_data;
	rrs_res_t  out_res;

	// The request payload sits unpadded in the low bits of tdata.
	assign in_data = rrs_data_t'(s_axis_tdata[$bits(rrs_data_t)-1:0]);

	// The controller owns the handshakes and the sequencing of each request.
	rrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds all storage and the result register.
	rrs_datapath #(
		.ARCH_REGS (ARCH_REGS),
		.PHYS_REGS (PHYS_REGS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.sts     (sts),
		.in_op   (s_axis_tuser[OP_W-1:0]),
		.in_data (in_data),
		.out_res (out_res)
	);

	// The result struct is zero-extended to whole bytes.
	assign m_axis_tdata = M_TDATA_W'(out_res);

endmodule
`default_nettype wire
